FILE: rtl/assert_macros.svh
// Assertion macros shared by the mixer RTL.
// Expect signals clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/ddm_pkg.sv
// Shared constants, register indexes and pipeline word types of the mixer.
// No dependencies.
package ddm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = 1 << (FRAC_BITS - 1);
    localparam int CMD_W     = 16;                      // command and wheel width
    localparam int LIM_W     = 15;                      // speed limit register width
    localparam int PROD_W    = 2 * FRAC_BITS + 2;       // command * limit
    localparam int MAG_W     = FRAC_BITS + 2;           // wheel magnitude before rescale
    localparam int Q_W       = FRAC_BITS + 1;           // rescaled magnitude
    localparam int NUM_W     = MAG_W + FRAC_BITS + 1;   // divider dividend
    localparam int DIV_STAGES = Q_W + 1;                // prep plus one stage per bit
    localparam int IDX_W     = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_SPEED       = 2'd0,
        REG_BACKWARD_FACTOR = 2'd1,
        REG_ADVANCE_INVERT  = 2'd2,
        REG_TURN_INVERT     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LIM_W-1:0] max_speed;
        logic [LIM_W-1:0] backward_factor;
        logic             advance_invert;
        logic             turn_invert;
    } cfg_t;

    // mixed wheels, split into magnitude and sign
    typedef struct packed {
        logic [MAG_W-1:0] lmag;
        logic             lneg;
        logic [MAG_W-1:0] rmag;
        logic             rneg;
        logic [MAG_W-1:0] peak;
        logic             norm;
    } front_t;

    // one divider lane
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic [MAG_W-1:0] rem;
        logic [Q_W-1:0]   nlo;
        logic [Q_W-1:0]   quo;
    } lane_t;

    typedef struct packed {
        lane_t            l;
        lane_t            r;
        logic [MAG_W-1:0] peak;
        logic             norm;
    } div_stage_t;

endpackage

FILE: rtl/ddm_front.sv
// Four-stage front end: invert and clamp, scale by limit, mix, peak detect.
// Depends on ddm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ddm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ddm_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    input  logic signed [ddm_pkg::CMD_W-1:0]   advance_cmd,
    input  logic signed [ddm_pkg::CMD_W-1:0]   turn_cmd,
    output logic                               up_ready,
    output logic                               out_valid,
    output ddm_pkg::front_t                    out_word,
    input  logic                               dn_ready
);

    localparam int CW = ddm_pkg::CMD_W;
    localparam int PW = ddm_pkg::PROD_W;
    localparam int MW = ddm_pkg::MAG_W;
    localparam int LW = ddm_pkg::LIM_W;
    localparam logic signed [CW:0]   ONE_X = (CW+1)'(ddm_pkg::ONE);
    localparam logic signed [CW:0]   NONE_X = -ONE_X;
    localparam logic [LW-1:0]        ONE_L = LW'(ddm_pkg::ONE);
    localparam logic [MW-1:0]        ONE_M = MW'(ddm_pkg::ONE);
    localparam logic signed [PW-1:0] HALF_P = PW'(ddm_pkg::HALF);

    function automatic logic signed [CW-1:0] clamp_one(input logic signed [CW:0] x);
        logic signed [CW-1:0] y;
        begin
            if (x > ONE_X)
                y = ONE_X[CW-1:0];
            else if (x < NONE_X)
                y = NONE_X[CW-1:0];
            else
                y = x[CW-1:0];
            return y;
        end
    endfunction

    function automatic logic [MW-1:0] abs_mag(input logic signed [CW:0] x);
        logic signed [CW:0] a;
        begin
            a = x[CW] ? -x : x;
            return a[MW-1:0];
        end
    endfunction

    logic [3:0] v_reg;
    logic [4:0] en;

    // per-stage hold chain
    assign en[4] = dn_ready;
    assign en[3] = !v_reg[3] || en[4];
    assign en[2] = !v_reg[2] || en[3];
    assign en[1] = !v_reg[1] || en[2];
    assign en[0] = !v_reg[0] || en[1];
    assign up_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    // stage 1: invert, clamp, pick limit
    logic signed [CW:0]   adv_x, trn_x;
    logic signed [CW-1:0] adv_next, trn_next;
    logic [LW-1:0]        lim_sel, lim_next;
    logic                 backward;
    logic signed [CW-1:0] adv_reg, trn_reg;
    logic [LW-1:0]        lim_reg;

    always_comb
    begin
        adv_x = {advance_cmd[CW-1], advance_cmd};
        trn_x = {turn_cmd[CW-1], turn_cmd};
        if (cfg.advance_invert) adv_x = -adv_x;
        if (cfg.turn_invert)    trn_x = -trn_x;
        adv_next = clamp_one(adv_x);
        trn_next = clamp_one(trn_x);
        if (cfg.advance_invert)
            backward = !adv_next[CW-1];
        else
            backward = adv_next[CW-1] || (adv_next == '0);
        lim_sel  = backward ? cfg.backward_factor : cfg.max_speed;
        lim_next = (lim_sel > ONE_L) ? ONE_L : lim_sel;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            adv_reg <= adv_next;
            trn_reg <= trn_next;
            lim_reg <= lim_next;
        end
    end

    // stage 2: scale both commands
    logic signed [2*CW-1:0] pa_full, pt_full;
    logic signed [PW-1:0]   pa_reg, pt_reg;

    always_comb
    begin
        pa_full = adv_reg * $signed({1'b0, lim_reg});
        pt_full = trn_reg * $signed({1'b0, lim_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pa_reg <= pa_full[PW-1:0];
            pt_reg <= pt_full[PW-1:0];
        end
    end

    // stage 3: round to nearest (ties up), then mix
    logic signed [PW-1:0] pa_rnd, pt_rnd;
    logic signed [CW-1:0] base, turn;
    logic signed [CW:0]   left_next, right_next;
    logic signed [CW:0]   left_reg, right_reg;

    always_comb
    begin
        pa_rnd = (pa_reg + HALF_P) >>> ddm_pkg::FRAC_BITS;
        pt_rnd = (pt_reg + HALF_P) >>> ddm_pkg::FRAC_BITS;
        base   = pa_rnd[CW-1:0];
        turn   = pt_rnd[CW-1:0];
        left_next  = {base[CW-1], base} - {turn[CW-1], turn};
        right_next = {base[CW-1], base} + {turn[CW-1], turn};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    // stage 4: magnitudes and peak
    ddm_pkg::front_t out_next;
    ddm_pkg::front_t out_reg;

    always_comb
    begin
        out_next.lmag = abs_mag(left_reg);
        out_next.lneg = left_reg[CW];
        out_next.rmag = abs_mag(right_reg);
        out_next.rneg = right_reg[CW];
        out_next.peak = (out_next.rmag > out_next.lmag) ? out_next.rmag : out_next.lmag;
        out_next.norm = out_next.peak > ONE_M;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            out_reg <= out_next;
    end

    assign out_valid = v_reg[3];
    assign out_word  = out_reg;

    `ASSERT_NEXT(a_front_hold, v_reg[3] && !dn_ready, v_reg[3] && $stable(out_reg))
    `ASSERT_IMPLY(a_front_full, !up_ready, v_reg == 4'b1111)
    `ASSERT_IMPLY(a_front_norm, v_reg[3] && out_reg.norm, out_reg.peak != '0)

endmodule

FILE: rtl/ddm_divider.sv
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// Computes round(mag * ONE / peak). Depends on ddm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ddm_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  ddm_pkg::front_t         in_word,
    output logic                    up_ready,
    output logic                    out_valid,
    output ddm_pkg::div_stage_t     out_word,
    input  logic                    dn_ready
);

    localparam int NST = ddm_pkg::DIV_STAGES;
    localparam int MW  = ddm_pkg::MAG_W;
    localparam int QW  = ddm_pkg::Q_W;
    localparam int NW  = ddm_pkg::NUM_W;

    // dividend = mag * ONE + peak / 2; the upper bits already sit below peak
    function automatic ddm_pkg::lane_t lane_prep(input logic [MW-1:0] mag, input logic neg,
                                                 input logic [MW-1:0] peak);
        logic [NW-1:0]  num;
        ddm_pkg::lane_t y;
        begin
            num   = {1'b0, mag, {ddm_pkg::FRAC_BITS{1'b0}}} + NW'(peak >> 1);
            y.mag = mag;
            y.neg = neg;
            y.rem = num[NW-1:QW];
            y.nlo = num[QW-1:0];
            y.quo = '0;
            return y;
        end
    endfunction

    function automatic ddm_pkg::lane_t lane_step(input ddm_pkg::lane_t x,
                                                 input logic [MW-1:0] d);
        logic [MW:0]    t;
        logic [MW:0]    diff;
        ddm_pkg::lane_t y;
        begin
            y    = x;
            t    = {x.rem, x.nlo[QW-1]};
            diff = t - {1'b0, d};
            if (t >= {1'b0, d})
            begin
                y.rem = diff[MW-1:0];
                y.quo = {x.quo[QW-2:0], 1'b1};
            end
            else
            begin
                y.rem = t[MW-1:0];
                y.quo = {x.quo[QW-2:0], 1'b0};
            end
            y.nlo = {x.nlo[QW-2:0], 1'b0};
            return y;
        end
    endfunction

    ddm_pkg::div_stage_t st_reg  [NST];
    ddm_pkg::div_stage_t st_next [NST];
    logic [NST-1:0]      v_reg;
    logic [NST:0]        en;

    assign en[NST]  = dn_ready;
    assign up_ready = en[0];

    // first stage: form the dividend
    always_comb
    begin
        st_next[0].l    = lane_prep(in_word.lmag, in_word.lneg, in_word.peak);
        st_next[0].r    = lane_prep(in_word.rmag, in_word.rneg, in_word.peak);
        st_next[0].peak = in_word.peak;
        st_next[0].norm = in_word.norm;
    end

    genvar k;
    generate
        for (k = 0; k < NST; k++)
        begin : g_stage
            assign en[k] = !v_reg[k] || en[k+1];

            if (k > 0)
            begin : g_step
                // one quotient bit per lane
                always_comb
                begin
                    st_next[k].l    = lane_step(st_reg[k-1].l, st_reg[k-1].peak);
                    st_next[k].r    = lane_step(st_reg[k-1].r, st_reg[k-1].peak);
                    st_next[k].peak = st_reg[k-1].peak;
                    st_next[k].norm = st_reg[k-1].norm;
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[k] <= 1'b0;
                    else if (en[k])
                        v_reg[k] <= v_reg[k-1];
                end
            end
            else
            begin : g_first
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        v_reg[k] <= 1'b0;
                    else if (en[k])
                        v_reg[k] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    assign out_valid = v_reg[NST-1];
    assign out_word  = st_reg[NST-1];

    `ASSERT_IMPLY(a_div_full, !up_ready, &v_reg)
    `ASSERT_NEXT(a_div_hold, out_valid && !dn_ready, out_valid && $stable(out_word))
    `ASSERT_IMPLY(a_div_quo, out_valid && out_word.norm,
                  out_word.l.quo <= QW'(ddm_pkg::ONE) && out_word.r.quo <= QW'(ddm_pkg::ONE))

endmodule

FILE: rtl/differential_drive_mixer.sv
// Differential drive mixer, top level: configuration registers, front end,
// rescaling divider and output register. Depends on ddm_pkg, ddm_front, ddm_divider.
//
// Arcade mixing of an advance and a turn command (Q2.14) into left and right
// wheel drive. One word is accepted per clock and one result word leaves per
// clock while m_tready is high. The path holds 4 front-end stages, 16 divider
// stages (dividend set-up plus one quotient bit per stage of the 15-bit
// restoring divider that rescales the wheels by their peak) and the output
// register. Stalls at the output collapse bubbles stage by stage, so input is
// still taken while a finished word waits. The user must write configuration
// via cfg_we/cfg_index/cfg_data with no word in flight, unchecked by the block.
`include "assert_macros.svh"
module differential_drive_mixer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] advance_cmd, [31:16] turn_cmd
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] left_wheel, [31:16] right_wheel
    output logic        m_tuser     // [0] normalized
);

    localparam int CW = ddm_pkg::CMD_W;
    localparam int MW = ddm_pkg::MAG_W;
    localparam logic signed [CW-1:0] ONE_W  = CW'(ddm_pkg::ONE);
    localparam logic signed [CW-1:0] NONE_W = -ONE_W;

    // configuration registers
    ddm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed       <= ddm_pkg::LIM_W'(13107);
            cfg_reg.backward_factor <= ddm_pkg::LIM_W'(8192);
            cfg_reg.advance_invert  <= 1'b0;
            cfg_reg.turn_invert     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (ddm_pkg::cfg_index_t'(cfg_index))
                ddm_pkg::REG_MAX_SPEED:       cfg_reg.max_speed       <= cfg_data;
                ddm_pkg::REG_BACKWARD_FACTOR: cfg_reg.backward_factor <= cfg_data;
                ddm_pkg::REG_ADVANCE_INVERT:  cfg_reg.advance_invert  <= cfg_data[0];
                ddm_pkg::REG_TURN_INVERT:     cfg_reg.turn_invert     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // front end
    logic            fr_valid, fr_ready;
    ddm_pkg::front_t fr_word;

    ddm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .advance_cmd (s_tdata[15:0]),
        .turn_cmd    (s_tdata[31:16]),
        .up_ready    (s_tready),
        .out_valid   (fr_valid),
        .out_word    (fr_word),
        .dn_ready    (fr_ready)
    );

    // rescaling divider
    logic                dv_valid, dv_ready;
    ddm_pkg::div_stage_t dv_word;

    ddm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_word   (fr_word),
        .up_ready  (fr_ready),
        .out_valid (dv_valid),
        .out_word  (dv_word),
        .dn_ready  (dv_ready)
    );

    // output register: pick rescaled or original magnitude, restore sign
    logic                 ov_reg;
    logic signed [CW-1:0] left_reg, right_reg, left_next, right_next;
    logic                 norm_reg;
    logic [MW-1:0]        lmag, rmag;

    assign dv_ready = !ov_reg || m_tready;

    always_comb
    begin
        lmag = dv_word.norm ? MW'(dv_word.l.quo) : dv_word.l.mag;
        rmag = dv_word.norm ? MW'(dv_word.r.quo) : dv_word.r.mag;
        left_next  = dv_word.l.neg ? -$signed(lmag) : $signed(lmag);
        right_next = dv_word.r.neg ? -$signed(rmag) : $signed(rmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (dv_ready)
            ov_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            norm_reg  <= dv_word.norm;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {right_reg, left_reg};
    assign m_tuser  = norm_reg;

    `ASSERT_IMPLY(a_left_range, m_tvalid, left_reg <= ONE_W && left_reg >= NONE_W)
    `ASSERT_IMPLY(a_right_range, m_tvalid, right_reg <= ONE_W && right_reg >= NONE_W)
    `ASSERT_IMPLY(a_norm_peak, m_tvalid && m_tuser,
                  left_reg == ONE_W || left_reg == NONE_W || right_reg == ONE_W || right_reg == NONE_W)

endmodule
